// File: design/pfd_pkg.sv
// Shared widths, register indexes, reset values and interface types for the
// PID controller with filtered derivative. No dependencies.
`timescale 1ns / 1ps

package pfd_pkg;

  // Field and datapath widths.
  localparam int DATA_W    = 32;
  localparam int TIME_W    = 31;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int NUM_W     = 51;
  localparam int DEN_W     = TIME_W + 2;
  localparam int FRAC_W    = 16;
  localparam int CFG_IDX_W = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_KP     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KI     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KD     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TAU    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LIM_LO = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LIM_HI = 3'd5;

  // Register values after reset.
  localparam logic signed [DATA_W-1:0] KP_RST     = 32'sh0000_4CCD;
  localparam logic signed [DATA_W-1:0] KI_RST     = 32'sh0000_0000;
  localparam logic signed [DATA_W-1:0] KD_RST     = 32'sh0000_4000;
  localparam logic        [TIME_W-1:0] TAU_RST    = 31'h0000_2666;
  localparam logic signed [DATA_W-1:0] LIM_LO_RST = 32'shFFF6_0000;
  localparam logic signed [DATA_W-1:0] LIM_HI_RST = 32'sh000A_0000;

  // Saturation bounds of a 32-bit result.
  localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

  // Request to the divider: start strobe and operands.
  typedef struct packed {
    logic                    start;
    logic signed [NUM_W-1:0] num;
    logic        [DEN_W-1:0] den;
  } div_req_t;

  // Divider answer: one-cycle done strobe and the saturated quotient.
  typedef struct packed {
    logic                     done;
    logic signed [DATA_W-1:0] quot;
  } div_rsp_t;

endpackage

// File: design/pid_filtered_derivative_antiwindup.sv
// PID controller with trapezoidal integrator, anti-windup clamp and a
// Tustin-filtered derivative on the measurement. Uses pfd_pkg, pfd_mul, pfd_div.
// An item passes the error step, six multiplier steps, the numerator step and the
// divider start; the derivative then waits for the 32-step divider unless its
// quotient saturates or 2*tau+dt is 0, and the result is loaded once the output
// register is free. The next item is taken no sooner than the cycle after that.
// Reset (asynchronous, active low) loads the register defaults and clears state.
`timescale 1ns / 1ps

module pid_filtered_derivative_antiwindup (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [pfd_pkg::DATA_W-1:0]   target_value_i,
  input  logic signed [pfd_pkg::DATA_W-1:0]   measured_value_i,
  input  logic        [pfd_pkg::TIME_W-1:0]   step_time_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [pfd_pkg::DATA_W-1:0]   drive_value_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic        [pfd_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic        [pfd_pkg::DATA_W-1:0]   cfg_data_i
);
  import pfd_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_ERR  = 4'd1;
  localparam logic [3:0] ST_KP   = 4'd2;
  localparam logic [3:0] ST_KI   = 4'd3;
  localparam logic [3:0] ST_KD   = 4'd4;
  localparam logic [3:0] ST_AH   = 4'd5;
  localparam logic [3:0] ST_TD   = 4'd6;
  localparam logic [3:0] ST_DD   = 4'd7;
  localparam logic [3:0] ST_NUM  = 4'd8;
  localparam logic [3:0] ST_DIV  = 4'd9;
  localparam logic [3:0] ST_WAIT = 4'd10;
  localparam logic [3:0] ST_OUT  = 4'd11;

  // Saturate a 33-bit signed value to 32 bits.
  function automatic logic signed [DATA_W-1:0] sat_w33(input logic signed [DATA_W:0] v);
    logic signed [DATA_W:0] hi;
    logic signed [DATA_W:0] lo;
    hi = {1'b0, Q_MAX};
    lo = {1'b1, Q_MIN};
    if (v > hi) begin
      return Q_MAX;
    end else if (v < lo) begin
      return Q_MIN;
    end
    return v[DATA_W-1:0];
  endfunction

  // Floor-shift a product right by 16 and saturate to 32 bits.
  function automatic logic signed [DATA_W-1:0] sat_shr16(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] s;
    s = p >>> FRAC_W;
    if (s > 64'sh0000_0000_7FFF_FFFF) begin
      return Q_MAX;
    end else if (s < 64'shFFFF_FFFF_8000_0000) begin
      return Q_MIN;
    end
    return s[DATA_W-1:0];
  endfunction

  // Configuration registers.
  logic signed [DATA_W-1:0] kp_q, ki_q, kd_q, lim_lo_q, lim_hi_q;
  logic        [TIME_W-1:0] tau_q;

  // Controller state carried between items.
  logic signed [DATA_W-1:0] integ_q, dfilt_q, perr_q, pmeas_q;

  // Sequencer and output register.
  logic [3:0]               state_q, state_d;
  logic                     out_valid_q;
  logic signed [DATA_W-1:0] drive_q;

  // Working registers of the item in flight.
  logic signed [DATA_W-1:0] tgt_q, meas_q, err_q, dm_q, h_q, prop_q, a_q, inc_q;
  logic signed [DATA_W-1:0] ilo_q, ihi_q;
  logic        [TIME_W-1:0] dt_q;
  logic        [DEN_W-1:0]  den_q;
  logic signed [NUM_W-1:0]  num_q;

  // Shared units.
  logic signed [DATA_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_shr15, prod_shr16;
  div_req_t                 div_req;
  div_rsp_t                 div_rsp;

  // Combinational helpers for the arithmetic of each step.
  logic signed [DATA_W:0]   err_w, dm_w, hsum_w, lhi_w, llo_w, isum_w, iclamp_w;
  logic signed [DATA_W-1:0] lhi_s, llo_s;
  logic signed [DATA_W+1:0] drive_w, drive_c;
  logic                     commit;
  logic                     in_acc;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign drive_value_o = drive_q;

  // Operand selection for the shared multiplier, one product per step.
  always_comb begin
    case (state_q)
      ST_KP: begin
        mul_a = kp_q;
        mul_b = err_q;
      end
      ST_KI: begin
        mul_a = ki_q;
        mul_b = $signed({1'b0, dt_q});
      end
      ST_KD: begin
        mul_a = kd_q;
        mul_b = dm_q;
      end
      ST_AH: begin
        mul_a = a_q;
        mul_b = h_q;
      end
      ST_TD: begin
        mul_a = $signed({1'b0, tau_q});
        mul_b = dfilt_q;
      end
      ST_DD: begin
        mul_a = $signed({1'b0, dt_q});
        mul_b = dfilt_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  pfd_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  assign div_req.start = (state_q == ST_DIV) && (den_q != '0);
  assign div_req.num   = num_q;
  assign div_req.den   = den_q;

  pfd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Per-step arithmetic.
  assign prod_shr15 = prod >>> 15;
  assign prod_shr16 = prod >>> FRAC_W;
  assign err_w  = $signed({meas_q[DATA_W-1], meas_q}) - $signed({tgt_q[DATA_W-1], tgt_q});
  assign dm_w   = $signed({meas_q[DATA_W-1], meas_q}) - $signed({pmeas_q[DATA_W-1], pmeas_q});
  assign hsum_w = $signed({err_q[DATA_W-1], err_q}) + $signed({perr_q[DATA_W-1], perr_q});
  assign lhi_w  = $signed({lim_hi_q[DATA_W-1], lim_hi_q}) - $signed({prop_q[DATA_W-1], prop_q});
  assign llo_w  = $signed({lim_lo_q[DATA_W-1], lim_lo_q}) - $signed({prop_q[DATA_W-1], prop_q});
  assign lhi_s  = sat_w33(lhi_w);
  assign llo_s  = sat_w33(llo_w);
  assign isum_w = $signed({integ_q[DATA_W-1], integ_q}) + $signed({inc_q[DATA_W-1], inc_q});

  // Anti-windup clamp: lower bound first, upper bound last.
  always_comb begin
    iclamp_w = isum_w;
    if (iclamp_w < $signed({ilo_q[DATA_W-1], ilo_q})) begin
      iclamp_w = $signed({ilo_q[DATA_W-1], ilo_q});
    end
    if (iclamp_w > $signed({ihi_q[DATA_W-1], ihi_q})) begin
      iclamp_w = $signed({ihi_q[DATA_W-1], ihi_q});
    end
  end

  // Output sum clamped by the upper limit first, then the lower limit.
  assign drive_w = $signed({{2{prop_q[DATA_W-1]}}, prop_q})
                 + $signed({{2{integ_q[DATA_W-1]}}, integ_q})
                 + $signed({{2{dfilt_q[DATA_W-1]}}, dfilt_q});
  always_comb begin
    drive_c = drive_w;
    if (drive_c > $signed({{2{lim_hi_q[DATA_W-1]}}, lim_hi_q})) begin
      drive_c = $signed({{2{lim_hi_q[DATA_W-1]}}, lim_hi_q});
    end
    if (drive_c < $signed({{2{lim_lo_q[DATA_W-1]}}, lim_lo_q})) begin
      drive_c = $signed({{2{lim_lo_q[DATA_W-1]}}, lim_lo_q});
    end
  end

  assign commit = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_ERR;
      ST_ERR:  state_d = ST_KP;
      ST_KP:   state_d = ST_KI;
      ST_KI:   state_d = ST_KD;
      ST_KD:   state_d = ST_AH;
      ST_AH:   state_d = ST_TD;
      ST_TD:   state_d = ST_DD;
      ST_DD:   state_d = ST_NUM;
      ST_NUM:  state_d = ST_DIV;
      ST_DIV:  state_d = (den_q == '0) ? ST_OUT : ST_WAIT;
      ST_WAIT: if (div_rsp.done) state_d = ST_OUT;
      ST_OUT:  if (commit) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Control, configuration and controller state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      kp_q        <= KP_RST;
      ki_q        <= KI_RST;
      kd_q        <= KD_RST;
      tau_q       <= TAU_RST;
      lim_lo_q    <= LIM_LO_RST;
      lim_hi_q    <= LIM_HI_RST;
      integ_q     <= '0;
      dfilt_q     <= '0;
      perr_q      <= '0;
      pmeas_q     <= '0;
    end else begin
      state_q <= state_d;

      // Register writes; unknown indexes are ignored.
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_KP:     kp_q     <= $signed(cfg_data_i);
          REG_KI:     ki_q     <= $signed(cfg_data_i);
          REG_KD:     kd_q     <= $signed(cfg_data_i);
          REG_TAU:    tau_q    <= cfg_data_i[TIME_W-1:0];
          REG_LIM_LO: lim_lo_q <= $signed(cfg_data_i);
          REG_LIM_HI: lim_hi_q <= $signed(cfg_data_i);
          default: ;
        endcase
      end

      // Integrator update once the increment is known.
      if (state_q == ST_DD) begin
        integ_q <= iclamp_w[DATA_W-1:0];
      end

      // Filtered derivative: zero for a zero denominator, else the quotient.
      if (state_q == ST_DIV && den_q == '0) begin
        dfilt_q <= '0;
      end else if (state_q == ST_WAIT && div_rsp.done) begin
        dfilt_q <= div_rsp.quot;
      end

      // Output register and history update when the result item is loaded.
      if (commit) begin
        out_valid_q <= 1'b1;
        perr_q      <= err_q;
        pmeas_q     <= meas_q;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working registers of the item in flight.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          tgt_q  <= target_value_i;
          meas_q <= measured_value_i;
          dt_q   <= step_time_i;
        end
      end
      ST_ERR: begin
        err_q <= sat_w33(err_w);
        dm_q  <= sat_w33(dm_w);
        den_q <= {1'b0, tau_q, 1'b0} + {2'b00, dt_q};
      end
      ST_KP: begin
        h_q <= hsum_w[DATA_W:1];
      end
      ST_KI: begin
        prop_q <= sat_shr16(prod);
      end
      ST_KD: begin
        a_q   <= sat_shr16(prod);
        ihi_q <= lhi_s[DATA_W-1] ? '0 : lhi_s;
        ilo_q <= llo_s[DATA_W-1] ? llo_s : '0;
      end
      ST_AH: begin
        num_q <= prod_shr15[NUM_W-1:0];
      end
      ST_TD: begin
        inc_q <= sat_shr16(prod);
      end
      ST_DD: begin
        num_q <= num_q + prod_shr15[NUM_W-1:0];
      end
      ST_NUM: begin
        num_q <= num_q - prod_shr16[NUM_W-1:0];
      end
      ST_OUT: begin
        if (commit) begin
          drive_q <= drive_c[DATA_W-1:0];
        end
      end
      default: ;
    endcase
  end

endmodule

// File: design/pfd_mul.sv
// Shared 32 x 32 signed multiplier with a registered 64-bit product.
// Depends on pfd_pkg for the widths.
`timescale 1ns / 1ps

module pfd_mul (
  input  logic                             clk_i,
  input  logic signed [pfd_pkg::DATA_W-1:0] a_i,
  input  logic signed [pfd_pkg::DATA_W-1:0] b_i,
  output logic signed [pfd_pkg::PROD_W-1:0] p_o
);
  import pfd_pkg::*;

  logic signed [PROD_W-1:0] p_q;

  // The product is registered: it is ready in the cycle after the operands are presented.
  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

// File: design/pfd_div.sv
// Iterative signed divider: truncated quotient of num * 2^16 / den,
// saturated to 32 bits, one quotient bit per cycle. Depends on pfd_pkg.
`timescale 1ns / 1ps

module pfd_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pfd_pkg::div_req_t req_i,
  output pfd_pkg::div_rsp_t rsp_o
);
  import pfd_pkg::*;

  localparam logic [1:0] DV_IDLE = 2'd0;
  localparam logic [1:0] DV_RUN  = 2'd1;
  localparam logic [1:0] DV_FIX  = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [4:0]        cnt_q, cnt_d;
  logic              done_q, done_d;
  logic [DEN_W-1:0]  rem_q, rem_d;
  logic [DATA_W-1:0] sh_q, sh_d;
  logic [DEN_W-1:0]  den_q, den_d;
  logic              neg_q, neg_d;
  logic signed [DATA_W-1:0] res_q, res_d;

  logic [NUM_W-1:0]  mag;
  logic              big;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;
  logic              ge;

  // Magnitude of the dividend and the check for a quotient of 2^32 or more.
  assign mag   = req_i.num[NUM_W-1] ? NUM_W'(-req_i.num) : req_i.num;
  assign big   = mag >= {2'b00, req_i.den, 16'h0000};

  // One restoring step: bring down the next dividend bit and try to subtract.
  assign trial = {rem_q, sh_q[DATA_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = trial >= {1'b0, den_q};

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    rem_d   = rem_q;
    sh_d    = sh_q;
    den_d   = den_q;
    neg_d   = neg_q;
    res_d   = res_q;
    case (state_q)
      DV_IDLE: begin
        if (req_i.start) begin
          neg_d = req_i.num[NUM_W-1];
          den_d = req_i.den;
          if (big) begin
            res_d  = req_i.num[NUM_W-1] ? Q_MIN : Q_MAX;
            done_d = 1'b1;
          end else begin
            rem_d   = mag[DEN_W+FRAC_W-1:FRAC_W];
            sh_d    = {mag[FRAC_W-1:0], 16'h0000};
            cnt_d   = '0;
            state_d = DV_RUN;
          end
        end
      end
      DV_RUN: begin
        rem_d = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        sh_d  = {sh_q[DATA_W-2:0], ge};
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          state_d = DV_FIX;
        end
      end
      DV_FIX: begin
        // Apply the sign and saturate the magnitude to the 32-bit range.
        if (neg_q) begin
          res_d = (sh_q > 32'h8000_0000) ? Q_MIN : $signed(32'(32'h0 - sh_q));
        end else begin
          res_d = sh_q[DATA_W-1] ? Q_MAX : $signed(sh_q);
        end
        done_d  = 1'b1;
        state_d = DV_IDLE;
      end
      default: begin
        state_d = DV_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DV_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    sh_q  <= sh_d;
    den_q <= den_d;
    neg_q <= neg_d;
    res_q <= res_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = res_q;

endmodule

// File: test/pid_drive_checker.sv
// Checker for the PID controller: watches the sample, drive and register
// channels, predicts each drive item and compares it. Depends on pfd_pkg.
`timescale 1ns / 1ps

module pid_drive_checker
  import pfd_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  logic signed [DATA_W-1:0]   target_value_i,
  input  logic signed [DATA_W-1:0]   measured_value_i,
  input  logic        [TIME_W-1:0]   step_time_i,
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  logic signed [DATA_W-1:0]   drive_value_i,
  input  logic                       cfg_valid_i,
  input  logic                       cfg_ready_i,
  input  logic        [CFG_IDX_W-1:0] cfg_index_i,
  input  logic        [DATA_W-1:0]   cfg_data_i,
  output int                         pending_o,
  output int                         mismatches_o
);

  // The derivative quotient is limited to this magnitude before scaling.
  localparam longint QUOT_BOUND = 64'sd8589934592;

  // Register copies.
  logic signed [DATA_W-1:0] kp_q;
  logic signed [DATA_W-1:0] ki_q;
  logic signed [DATA_W-1:0] kd_q;
  logic        [TIME_W-1:0] tau_q;
  logic signed [DATA_W-1:0] lim_lo_q;
  logic signed [DATA_W-1:0] lim_hi_q;

  // Controller state.
  logic signed [DATA_W-1:0] integ_q;
  logic signed [DATA_W-1:0] deriv_q;
  logic signed [DATA_W-1:0] prev_err_q;
  logic signed [DATA_W-1:0] prev_meas_q;

  logic signed [DATA_W-1:0] drive_expected[$];
  int                       mismatch_count = 0;

  assign mismatches_o = mismatch_count;

  function automatic longint clip32(input longint x);
    if (x > longint'(Q_MAX)) return longint'(Q_MAX);
    if (x < longint'(Q_MIN)) return longint'(Q_MIN);
    return x;
  endfunction

  // Computes the drive value for one sample and advances the controller state.
  function automatic logic signed [DATA_W-1:0] predict_drive(
    input logic signed [DATA_W-1:0] target,
    input logic signed [DATA_W-1:0] meas,
    input logic        [TIME_W-1:0] dt_raw
  );
    longint dt, tau, err, prop, win_hi, win_lo, rate, half, acc;
    longint den, dm, num, quot, rem, deriv, drv;
    dt   = longint'(dt_raw);
    tau  = longint'(tau_q);
    err  = clip32(longint'(meas) - longint'(target));
    prop = clip32((longint'(kp_q) * err) >>> 16);

    // Anti-windup window: narrowed by the proportional term, always holds zero.
    win_hi = clip32(longint'(lim_hi_q) - prop);
    if (win_hi < 0) win_hi = 0;
    win_lo = clip32(longint'(lim_lo_q) - prop);
    if (win_lo > 0) win_lo = 0;

    // Trapezoidal integrator step, lower bound first and upper bound last.
    rate = clip32((longint'(ki_q) * dt) >>> 16);
    half = (err + longint'(prev_err_q)) >>> 1;
    acc  = longint'(integ_q) + clip32((rate * half) >>> 16);
    if (acc < win_lo) acc = win_lo;
    if (acc > win_hi) acc = win_hi;
    integ_q = acc[DATA_W-1:0];

    // Filtered derivative on the measurement; a zero denominator clears it.
    den = 2 * tau + dt;
    if (den == 0) begin
      deriv = 0;
    end else begin
      dm   = clip32(longint'(meas) - longint'(prev_meas_q));
      num  = ((longint'(kd_q) * dm) >>> 15) + ((tau * longint'(deriv_q)) >>> 15)
           - ((dt * longint'(deriv_q)) >>> 16);
      quot = num / den;
      rem  = num % den;
      if (quot > QUOT_BOUND) quot = QUOT_BOUND;
      if (quot < -QUOT_BOUND) quot = -QUOT_BOUND;
      deriv = clip32(quot * 65536 + (rem * 65536) / den);
    end
    deriv_q = deriv[DATA_W-1:0];

    // Output clamp: the high limit first, so crossed limits yield the low one.
    drv = prop + acc + deriv;
    if (drv > longint'(lim_hi_q)) drv = longint'(lim_hi_q);
    if (drv < longint'(lim_lo_q)) drv = longint'(lim_lo_q);

    prev_err_q  = err[DATA_W-1:0];
    prev_meas_q = meas;
    return drv[DATA_W-1:0];
  endfunction

  // Register write; unknown indexes leave everything as it was.
  function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [DATA_W-1:0] data);
    case (idx)
      REG_KP:     kp_q     = data;
      REG_KI:     ki_q     = data;
      REG_KD:     kd_q     = data;
      REG_TAU:    tau_q    = data[TIME_W-1:0];
      REG_LIM_LO: lim_lo_q = data;
      REG_LIM_HI: lim_hi_q = data;
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t ns: drive check: %s", $time, what);
    mismatch_count++;
  endtask

  // Sample every handshake at the clock edge, predict on input, compare on output.
  always @(posedge clk_i or negedge rst_ni) begin : watch
    logic signed [DATA_W-1:0] want;
    if (!rst_ni) begin
      kp_q        = KP_RST;
      ki_q        = KI_RST;
      kd_q        = KD_RST;
      tau_q       = TAU_RST;
      lim_lo_q    = LIM_LO_RST;
      lim_hi_q    = LIM_HI_RST;
      integ_q     = '0;
      deriv_q     = '0;
      prev_err_q  = '0;
      prev_meas_q = '0;
      drive_expected.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) apply_register(cfg_index_i, cfg_data_i);
      if (in_valid_i && in_ready_i) begin
        drive_expected.push_back(predict_drive(target_value_i, measured_value_i,
                                               step_time_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (drive_expected.size() == 0) begin
          report_mismatch($sformatf("drive item %0d with none outstanding",
                                    drive_value_i));
        end else begin
          want = drive_expected.pop_front();
          if (drive_value_i !== want) begin
            report_mismatch($sformatf("drive_value %0d, predicted %0d",
                                      drive_value_i, want));
          end
        end
      end
      pending_o <= drive_expected.size();
    end
  end

endmodule

// File: test/pid_filtered_derivative_antiwindup_tb.sv
// Top of the PID controller testbench: clock, reset, directed and random
// samples, register settings and the verdict. Depends on pfd_pkg, pid_drive_checker and the controller.
`timescale 1ns / 1ps

module pid_filtered_derivative_antiwindup_tb;
  import pfd_pkg::*;

  localparam int CLK_HALF     = 2;
  localparam int RESET_CYCLES = 10;
  localparam int STALL_LIMIT  = 4000;
  localparam int TAIL_CYCLES  = 60;
  localparam int PHASES       = 3;
  localparam int SETTINGS_PER_PHASE = 4;
  localparam int ITEMS_PER_SETTING  = 103;
  localparam int Q1_INT       = 65536;

  // Indexes beyond the register file; writes to them must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  localparam logic signed [DATA_W-1:0] Q_ONE     = 32'sh0001_0000;
  localparam logic signed [DATA_W-1:0] Q_HALF    = 32'sh0000_8000;
  localparam logic signed [DATA_W-1:0] Q_TEN     = 32'sh000A_0000;
  localparam logic signed [DATA_W-1:0] Q_HUNDRED = 32'sh0064_0000;
  localparam logic        [TIME_W-1:0] TIME_MAX  = 31'h7FFF_FFFF;
  localparam logic        [TIME_W-1:0] TIME_ONE  = 31'h0001_0000;

  logic                        clk_i            = 1'b0;
  logic                        rst_ni           = 1'b0;
  logic                        in_valid_i       = 1'b0;
  logic                        in_ready_o;
  logic signed [DATA_W-1:0]    target_value_i   = '0;
  logic signed [DATA_W-1:0]    measured_value_i = '0;
  logic        [TIME_W-1:0]    step_time_i      = '0;
  logic                        out_valid_o;
  logic                        out_ready_i      = 1'b0;
  logic signed [DATA_W-1:0]    drive_value_o;
  logic                        cfg_valid_i      = 1'b0;
  logic                        cfg_ready_o;
  logic        [CFG_IDX_W-1:0] cfg_index_i      = '0;
  logic        [DATA_W-1:0]    cfg_data_i       = '0;

  int pending;
  int mismatches;
  int idle_cycles   = 0;
  int send_idle_pct = 20;
  int recv_idle_pct = 86;

  // Slowly moving plant used for well-formed sample sequences.
  logic signed [DATA_W-1:0] plant_target = '0;
  logic signed [DATA_W-1:0] plant_meas   = '0;

  always begin
    #(CLK_HALF) clk_i = 1'b1;
    #(CLK_HALF) clk_i = 1'b0;
  end

  pid_filtered_derivative_antiwindup u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .target_value_i  (target_value_i),
    .measured_value_i(measured_value_i),
    .step_time_i     (step_time_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .drive_value_o   (drive_value_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  pid_drive_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .target_value_i  (target_value_i),
    .measured_value_i(measured_value_i),
    .step_time_i     (step_time_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .drive_value_i   (drive_value_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .pending_o       (pending),
    .mismatches_o    (mismatches)
  );

  // Drive-side back-pressure.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Watchdog: ends the run when no item moves on any channel for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)
        || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Mostly moderate values, sometimes the extremes or the full range.
  function automatic logic [DATA_W-1:0] draw_q16(input int span);
    case ($urandom_range(0, 9))
      0:       return Q_MAX;
      1:       return Q_MIN;
      2, 3:    return $urandom();
      default: return $urandom_range(0, 2 * span) - span;
    endcase
  endfunction

  // Offers one sample, after a random gap, and returns at the edge that takes it.
  task automatic send_sample(input logic signed [DATA_W-1:0] target,
                             input logic signed [DATA_W-1:0] meas,
                             input logic        [TIME_W-1:0] dt);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    target_value_i   <= target;
    measured_value_i <= meas;
    step_time_i      <= dt;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Holds off new samples until every outstanding drive item has come back.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  // Writes all six registers once the controller is idle.
  task automatic load_setting(input logic [DATA_W-1:0] kp, input logic [DATA_W-1:0] ki,
                              input logic [DATA_W-1:0] kd, input logic [DATA_W-1:0] tau,
                              input logic [DATA_W-1:0] lo, input logic [DATA_W-1:0] hi);
    drain();
    write_reg(REG_KP, kp);
    write_reg(REG_KI, ki);
    write_reg(REG_KD, kd);
    write_reg(REG_TAU, tau);
    write_reg(REG_LIM_LO, lo);
    write_reg(REG_LIM_HI, hi);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic load_random_setting();
    logic [DATA_W-1:0] tau, lo, hi;
    case ($urandom_range(0, 7))
      0:       tau = '0;
      1:       tau = 32'hFFFF_FFFF;
      2:       tau = $urandom();
      default: tau = $urandom_range(0, Q1_INT);
    endcase
    case ($urandom_range(0, 9))
      0: begin
        // Crossed output limits.
        lo = $urandom_range(0, 20 * Q1_INT);
        hi = -$urandom_range(0, 20 * Q1_INT);
      end
      1: begin
        lo = Q_MIN;
        hi = Q_MAX;
      end
      default: begin
        lo = -$urandom_range(0, 50 * Q1_INT);
        hi = $urandom_range(0, 50 * Q1_INT);
      end
    endcase
    load_setting(draw_q16(4 * Q1_INT), draw_q16(2 * Q1_INT), draw_q16(Q1_INT / 2),
                 tau, lo, hi);
  endtask

  // Mostly a plant tracking its set point at small steps; the rest is noise.
  task automatic send_random_sample();
    logic signed [DATA_W-1:0] t, m;
    logic        [TIME_W-1:0] dt;
    case ($urandom_range(0, 9))
      7: begin
        t  = $urandom();
        m  = $urandom();
        dt = $urandom();
      end
      8: begin
        t = draw_q16(20 * Q1_INT);
        m = draw_q16(20 * Q1_INT);
        case ($urandom_range(0, 3))
          0:       dt = '0;
          1:       dt = 31'd1;
          2:       dt = TIME_MAX;
          default: dt = $urandom();
        endcase
      end
      default: begin
        if ($urandom_range(0, 19) == 0) plant_target = draw_q16(20 * Q1_INT);
        plant_meas = plant_meas + ((plant_target - plant_meas) >>> 3)
                     + $urandom_range(0, Q1_INT / 4) - Q1_INT / 8;
        t  = plant_target;
        m  = plant_meas;
        dt = ($urandom_range(0, 9) == 0) ? '0 : $urandom_range(1, Q1_INT / 10);
      end
    endcase
    send_sample(t, m, dt);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Register defaults: zero step time, an ordinary sample, saturated errors.
    send_sample('0, '0, '0);
    send_sample(Q_ONE, 2 * Q_ONE, 31'd655);
    send_sample(Q_MAX, Q_MIN, TIME_MAX);
    send_sample(Q_MIN, Q_MAX, TIME_MAX);

    // Zero time constant: zero denominator, then a saturated quotient.
    load_setting(Q_ONE, Q_HALF, Q_ONE, '0, -Q_TEN, Q_TEN);
    send_sample('0, Q_ONE, '0);
    send_sample('0, 3 * Q_ONE, 31'd1);
    send_sample('0, -3 * Q_ONE, 31'd1);
    send_sample(Q_ONE, '0, '0);

    // Writes to unknown indexes must leave the setting alone.
    drain();
    write_reg(REG_SPARE_A, 32'hFFFF_FFFF);
    write_reg(REG_SPARE_B, '0);
    cfg_valid_i <= 1'b0;
    send_sample('0, Q_ONE, 31'd655);

    // Extreme gains and limits; the time constant write carries a stray top bit.
    load_setting(Q_MIN, Q_MAX, Q_MIN, 32'hFFFF_FFFF, Q_MIN, Q_MAX);
    send_sample(Q_MAX, Q_MIN, TIME_MAX);
    send_sample(Q_MIN, Q_MAX, TIME_MAX);
    send_sample('0, -1, 31'd1);
    send_sample(-1, '0, '0);

    // Crossed limits: the output sticks to the low limit.
    load_setting(Q_MAX, Q_MIN, Q_MAX, 32'd1, Q_HUNDRED, -Q_HUNDRED);
    send_sample('0, Q_ONE, 31'd1);
    send_sample(Q_MIN, Q_MAX, TIME_MAX);
    send_sample(Q_MAX, Q_MIN, '0);
    send_sample('0, '0, 31'd1);

    // Integrator windup against the clamp, then unwinding.
    load_setting(Q_ONE, Q_HUNDRED, '0, Q_ONE, -Q_ONE, Q_ONE);
    repeat (3) send_sample('0, 5 * Q_ONE, TIME_ONE);
    repeat (2) send_sample('0, -5 * Q_ONE, TIME_ONE);

    // Random settings under three idling patterns.
    for (int phase = 0; phase < PHASES; phase++) begin
      send_idle_pct = (phase == 0) ? 20 : (phase == 1) ? 86 : 0;
      recv_idle_pct = (phase == 0) ? 86 : (phase == 1) ? 20 : 0;
      for (int s = 0; s < SETTINGS_PER_PHASE; s++) begin
        load_random_setting();
        repeat (ITEMS_PER_SETTING) send_random_sample();
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: pid_filtered_derivative_antiwindup.f
design/pfd_pkg.sv
design/pfd_mul.sv
design/pfd_div.sv
design/pid_filtered_derivative_antiwindup.sv
test/pid_drive_checker.sv
test/pid_filtered_derivative_antiwindup_tb.sv
